### rtl/rgbhsv_pkg.sv
`timescale 1ns / 1ps

package rgbhsv_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned QW     = 16;
  localparam int unsigned HDEN_W = 11;
  localparam int unsigned SDEN_W = CH_W;

  typedef struct packed {
    logic [HDEN_W-1:0] hrem;
    logic [HDEN_W-1:0] hden;
    logic [QW-1:0]     hq;
    logic [SDEN_W-1:0] srem;
    logic [SDEN_W-1:0] sden;
    logic [QW-1:0]     sq;
    logic [CH_W-1:0]   bright;
    logic              grey;
    logic              sat_full;
  } stage_t;

endpackage

### rtl/rgbhsv_prep.sv
`timescale 1ns / 1ps

module rgbhsv_prep (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [rgbhsv_pkg::CH_W-1:0]    in_red,
  input  logic [rgbhsv_pkg::CH_W-1:0]    in_green,
  input  logic [rgbhsv_pkg::CH_W-1:0]    in_blue,
  output logic                           out_valid,
  output rgbhsv_pkg::stage_t             out_stage
);

  logic                         valid_r;
  rgbhsv_pkg::stage_t           stage_r;
  rgbhsv_pkg::stage_t           stage_nxt;
  logic [rgbhsv_pkg::CH_W-1:0]  mx;
  logic [rgbhsv_pkg::CH_W-1:0]  mn;
  logic [rgbhsv_pkg::CH_W-1:0]  d;
  logic [11:0]                  d12;
  logic [11:0]                  den12;
  logic [11:0]                  num12;
  logic [11:0]                  r12;
  logic [11:0]                  g12;
  logic [11:0]                  b12;

  always_comb begin
    mx = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    d     = mx - mn;
    d12   = 12'(d);
    r12   = 12'(in_red);
    g12   = 12'(in_green);
    b12   = 12'(in_blue);
    den12 = (d12 << 2) + (d12 << 1);
    // red-max with green below blue: hue = floor(65536*(6d-(b-g))/6d)
    priority if (mx == in_red) begin
      if (in_green >= in_blue) num12 = g12 - b12;
      else num12 = den12 - b12 + g12;
    end else if (mx == in_green) begin
      num12 = (d12 << 1) + b12 - r12;
    end else begin
      num12 = (d12 << 2) + r12 - g12;
    end
    stage_nxt.hrem     = num12[rgbhsv_pkg::HDEN_W-1:0];
    stage_nxt.hden     = den12[rgbhsv_pkg::HDEN_W-1:0];
    stage_nxt.hq       = '0;
    stage_nxt.sat_full = (d == mx);
    stage_nxt.srem     = (d == mx) ? '0 : d;
    stage_nxt.sden     = mx;
    stage_nxt.sq       = '0;
    stage_nxt.bright   = mx;
    stage_nxt.grey     = (d == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

### rtl/rgbhsv_cell.sv
`timescale 1ns / 1ps

module rgbhsv_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  rgbhsv_pkg::stage_t in_stage,
  output logic               out_valid,
  output rgbhsv_pkg::stage_t out_stage
);

  logic                            valid_r;
  rgbhsv_pkg::stage_t              stage_r;
  rgbhsv_pkg::stage_t              stage_nxt;
  logic [rgbhsv_pkg::HDEN_W:0]     h2;
  logic [rgbhsv_pkg::SDEN_W:0]     s2;
  logic [rgbhsv_pkg::HDEN_W:0]     hdiff;
  logic [rgbhsv_pkg::SDEN_W:0]     sdiff;
  logic                            hge;
  logic                            sge;

  // one restoring step for each divider lane
  always_comb begin
    stage_nxt = in_stage;
    h2    = {in_stage.hrem, 1'b0};
    s2    = {in_stage.srem, 1'b0};
    hdiff = h2 - {1'b0, in_stage.hden};
    sdiff = s2 - {1'b0, in_stage.sden};
    hge   = (h2 >= {1'b0, in_stage.hden});
    sge   = (s2 >= {1'b0, in_stage.sden});
    stage_nxt.hrem = hge ? hdiff[rgbhsv_pkg::HDEN_W-1:0]
                         : h2[rgbhsv_pkg::HDEN_W-1:0];
    stage_nxt.srem = sge ? sdiff[rgbhsv_pkg::SDEN_W-1:0]
                         : s2[rgbhsv_pkg::SDEN_W-1:0];
    stage_nxt.hq = {in_stage.hq[rgbhsv_pkg::QW-2:0], hge};
    stage_nxt.sq = {in_stage.sq[rgbhsv_pkg::QW-2:0], sge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

### rtl/rgb_to_hsv_pixel_core.sv
`timescale 1ns / 1ps

// RGB to HSV pixel converter. A transaction is taken whenever start is high;
// busy is always low, so one pixel may enter every clock. Each result passes
// one setup stage plus a row of 16 divider cells (one quotient bit of hue and
// saturation per cell), each registered, and is marked on the outputs by a
// one-cycle out_valid strobe. The receiver cannot stall the output; results
// must be captured in the cycle out_valid is high.

module rgb_to_hsv_pixel_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rgbhsv_pkg::CH_W-1:0]     in_red,
  input  logic [rgbhsv_pkg::CH_W-1:0]     in_green,
  input  logic [rgbhsv_pkg::CH_W-1:0]     in_blue,
  output logic                            out_valid,
  output logic [rgbhsv_pkg::QW-1:0]       out_hue,
  output logic [rgbhsv_pkg::QW-1:0]       out_saturation,
  output logic [rgbhsv_pkg::CH_W-1:0]     out_brightness
);

  logic               vld [0:rgbhsv_pkg::QW];
  rgbhsv_pkg::stage_t stg [0:rgbhsv_pkg::QW];
  rgbhsv_pkg::stage_t last;

  assign busy = 1'b0;

  rgbhsv_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (vld[0]),
    .out_stage (stg[0])
  );

  for (genvar i = 0; i < rgbhsv_pkg::QW; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[i]),
      .in_stage  (stg[i]),
      .out_valid (vld[i+1]),
      .out_stage (stg[i+1])
    );
  end

  assign last      = stg[rgbhsv_pkg::QW];
  assign out_valid = vld[rgbhsv_pkg::QW];

  always_comb begin
    out_hue        = last.grey ? '0 : last.hq;
    out_brightness = last.bright;
    priority if (last.bright == '0) begin
      out_saturation = '0;
    end else if (last.sat_full) begin
      out_saturation = '1;
    end else begin
      out_saturation = last.sq;
    end
  end

endmodule

### bench/rgb_to_hsv_pixel_checker.sv
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [rgbhsv_pkg::CH_W-1:0] in_red,
  input  logic [rgbhsv_pkg::CH_W-1:0] in_green,
  input  logic [rgbhsv_pkg::CH_W-1:0] in_blue,
  input  logic                        out_valid,
  input  logic [rgbhsv_pkg::QW-1:0]   out_hue,
  input  logic [rgbhsv_pkg::QW-1:0]   out_saturation,
  input  logic [rgbhsv_pkg::CH_W-1:0] out_brightness,
  output int                          fail_count,
  output int                          pending_count,
  output int                          checked_count
);

  localparam int unsigned FULL_TURN  = 65536;
  localparam int unsigned FRAC_MAX   = 65535;
  localparam int          FIFO_DEPTH = 32;

  typedef struct packed {
    logic [rgbhsv_pkg::QW-1:0]   hue;
    logic [rgbhsv_pkg::QW-1:0]   sat;
    logic [rgbhsv_pkg::CH_W-1:0] bright;
  } hsv_t;

  hsv_t       exp_fifo [0:FIFO_DEPTH-1];
  logic [4:0] wr_ptr_r;
  logic [4:0] rd_ptr_r;
  int         level_r;

  function automatic hsv_t hsv_of(logic [rgbhsv_pkg::CH_W-1:0] red,
                                  logic [rgbhsv_pkg::CH_W-1:0] green,
                                  logic [rgbhsv_pkg::CH_W-1:0] blue);
    int unsigned r, g, b, mx, mn, d, span, h, s;
    hsv_t res;
    r = red;
    g = green;
    b = blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    span = 6 * d;
    if (d == 0) begin
      h = 0;
    end else if (mx == r) begin
      if (g >= b) begin
        h = (FULL_TURN * (g - b)) / span;
      end else begin
        // wraps just below a full turn, rounded down, away from the turn boundary
        h = FULL_TURN - (FULL_TURN * (b - g) + span - 1) / span;
      end
    end else if (mx == g) begin
      h = (FULL_TURN * (2 * d + b - r)) / span;
    end else begin
      h = (FULL_TURN * (4 * d + r - g)) / span;
    end
    if (mx == 0) begin
      s = 0;
    end else begin
      s = (FULL_TURN * d) / mx;
      if (s > FRAC_MAX) s = FRAC_MAX;
    end
    res.hue    = h[rgbhsv_pkg::QW-1:0];
    res.sat    = s[rgbhsv_pkg::QW-1:0];
    res.bright = mx[rgbhsv_pkg::CH_W-1:0];
    return res;
  endfunction

  assign pending_count = level_r;

  always @(posedge clk) begin
    hsv_t exp_px;
    int   errs;
    int   level_nxt;
    errs      = 0;
    level_nxt = level_r;
    if (!rst_n) begin
      fail_count    <= 0;
      checked_count <= 0;
      level_r       <= 0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
    end else begin
      if (out_valid) begin
        if (level_nxt == 0) begin
          $display("%0t: unexpected result hue=%0d sat=%0d bright=%0d", $time,
                   out_hue, out_saturation, out_brightness);
          errs++;
        end else begin
          exp_px = exp_fifo[rd_ptr_r];
          rd_ptr_r <= rd_ptr_r + 5'd1;
          level_nxt--;
          checked_count <= checked_count + 1;
          if (out_hue !== exp_px.hue) begin
            $display("%0t: hue mismatch expected %0d actual %0d", $time,
                     exp_px.hue, out_hue);
            errs++;
          end
          if (out_saturation !== exp_px.sat) begin
            $display("%0t: saturation mismatch expected %0d actual %0d", $time,
                     exp_px.sat, out_saturation);
            errs++;
          end
          if (out_brightness !== exp_px.bright) begin
            $display("%0t: brightness mismatch expected %0d actual %0d", $time,
                     exp_px.bright, out_brightness);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        exp_fifo[wr_ptr_r] <= hsv_of(in_red, in_green, in_blue);
        wr_ptr_r <= wr_ptr_r + 5'd1;
        level_nxt++;
      end
      fail_count <= fail_count + errs;
      level_r    <= level_nxt;
    end
  end

endmodule

### bench/rgb_to_hsv_pixel_core_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_core_tb;

  localparam int RANDOM_PIXELS = 400;
  localparam int PIPE_DEPTH    = 17;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [rgbhsv_pkg::CH_W-1:0] in_red;
  logic [rgbhsv_pkg::CH_W-1:0] in_green;
  logic [rgbhsv_pkg::CH_W-1:0] in_blue;
  logic                        out_valid;
  logic [rgbhsv_pkg::QW-1:0]   out_hue;
  logic [rgbhsv_pkg::QW-1:0]   out_saturation;
  logic [rgbhsv_pkg::CH_W-1:0] out_brightness;

  int fail_count;
  int pending_count;
  int checked_count;
  int sent_count;
  bit burst_mode;

  rgb_to_hsv_pixel_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  rgb_to_hsv_pixel_checker u_hsv_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("rgb_to_hsv_pixel_core verification failed");
    $finish;
  end

  // Called at a rising edge; returns at the edge that accepts the transaction.
  task automatic send_pixel(input logic [rgbhsv_pkg::CH_W-1:0] r,
                            input logic [rgbhsv_pkg::CH_W-1:0] g,
                            input logic [rgbhsv_pkg::CH_W-1:0] b);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  function automatic logic [rgbhsv_pkg::CH_W-1:0] near_level(int base);
    int v;
    v = base + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[rgbhsv_pkg::CH_W-1:0];
  endfunction

  initial begin : stimulus
    int mode;
    int base;
    int lvl;
    int missing;
    logic [rgbhsv_pkg::CH_W-1:0] r, g, b;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_red     = '0;
    in_green   = '0;
    in_blue    = '0;
    sent_count = 0;
    burst_mode = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // black, white, grey, primaries, secondaries, ties, hue wrap, tiny spans
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd200, 8'd200, 8'd50);
    send_pixel(8'd200, 8'd50,  8'd200);
    send_pixel(8'd50,  8'd200, 8'd200);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd100, 8'd30,  8'd70);
    send_pixel(8'd70,  8'd100, 8'd30);
    send_pixel(8'd30,  8'd70,  8'd100);
    send_pixel(8'd170, 8'd85,  8'd255);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 25 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      case (mode)
        5, 6: begin
          base = $urandom_range(0, 255);
          r = near_level(base);
          g = near_level(base);
          b = near_level(base);
        end
        7: begin
          case ($urandom_range(0, 2))
            0: r = '0;
            1: g = '0;
            default: b = '0;
          endcase
        end
        8: begin
          case ($urandom_range(0, 2))
            0: g = r;
            1: b = r;
            default: b = g;
          endcase
        end
        9: begin
          lvl = $urandom_range(0, 2);
          r = (lvl == 0) ? 8'd0 : (lvl == 1) ? 8'd255 : r;
          lvl = $urandom_range(0, 2);
          g = (lvl == 0) ? 8'd0 : (lvl == 1) ? 8'd255 : g;
          lvl = $urandom_range(0, 2);
          b = (lvl == 0) ? 8'd0 : (lvl == 1) ? 8'd255 : b;
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
    start <= 1'b0;

    for (int i = 0; i < 2000 && pending_count > 0; i++) @(posedge clk);
    repeat (PIPE_DEPTH + 20) @(posedge clk);

    missing = pending_count;
    if (missing > 0) $display("%0t: %0d results never arrived", $time, missing);

    $display("Sent %0d pixels (directed corners plus random, near-grey, tie and",
             sent_count);
    $display("zero-channel mixes); %0d results compared.", checked_count);
    if (fail_count == 0 && missing == 0) begin
      $display("rgb_to_hsv_pixel_core verification clean");
    end else begin
      $display("rgb_to_hsv_pixel_core verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_prep.sv
rtl/rgbhsv_cell.sv
rtl/rgb_to_hsv_pixel_core.sv
bench/rgb_to_hsv_pixel_checker.sv
bench/rgb_to_hsv_pixel_core_tb.sv
